// ===== rtl/video_unit_register_interface_macros.svh =====
// Assertion macros shared by the video unit register interface RTL.
`ifndef VIDEO_UNIT_REGISTER_INTERFACE_MACROS_SVH
`define VIDEO_UNIT_REGISTER_INTERFACE_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define VURI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define VURI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vuri_pkg.sv =====
// Package: commands, register map, timing constants and memory port types.
package vuri_pkg;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Register map
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_SPR_ADDR = 3'd3;
    localparam logic [2:0] REG_SPR_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Control register bits
    localparam int CTRL_INC32_BIT = 2;
    localparam int CTRL_NMI_BIT   = 7;

    // Raster timing
    localparam logic [8:0] DOTS_PER_LINE   = 9'd341;
    localparam logic [8:0] VBLANK_LINE     = 9'd241;
    localparam logic [8:0] LINES_PER_FRAME = 9'd262;

    // Video address map
    localparam logic [13:0] NAME_BASE    = 14'h2000;
    localparam logic [13:0] PALETTE_BASE = 14'h3F00;
    localparam logic [13:0] INC_ONE      = 14'd1;
    localparam logic [13:0] INC_ROW      = 14'd32;

    // Store sizes
    localparam int NAME_DEPTH_DEF = 4096;
    localparam int SPRITE_DEPTH   = 256;
    localparam int PALETTE_DEPTH  = 32;

    // Source of the read buffer refill
    typedef enum logic [1:0] {
        FILL_ZERO = 2'd0,
        FILL_NAME = 2'd1,
        FILL_PAL  = 2'd2
    } fill_src_t;

    // Access request to the stores, one per accepted word
    typedef struct packed {
        logic        spr_we;
        logic        spr_re;
        logic [7:0]  spr_addr;
        logic        nam_we;
        logic        nam_re;
        logic [11:0] nam_addr;
        logic        pal_we;
        logic        pal_re;
        logic [4:0]  pal_addr;
        logic [7:0]  wdata;
    } mem_req_t;

    // Store read data and clearing status
    typedef struct packed {
        logic       busy;
        logic [7:0] spr_q;
        logic [7:0] nam_q;
        logic [7:0] pal_q;
    } mem_rsp_t;

    // Fold the backdrop mirrors of the upper palette half onto the lower half
    function automatic logic [4:0] pal_index(input logic [4:0] a);
        logic [4:0] idx;
        idx = a;
        if (a[4] && (a[1:0] == 2'b00))
        begin
            idx = {1'b0, a[3:0]};
        end
        return idx;
    endfunction

endpackage

// ===== rtl/vuri_store.sv =====
// Sprite, nametable and palette memories with the clearing sweep after reset.
module vuri_store #(
    parameter int NAME_STORE_DEPTH = vuri_pkg::NAME_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vuri_pkg::mem_req_t req,
    output vuri_pkg::mem_rsp_t rsp
);
    import vuri_pkg::*;

    localparam int NW = $clog2(NAME_STORE_DEPTH);

    logic [7:0]    sprite_mem [SPRITE_DEPTH];
    logic [7:0]    name_mem   [NAME_STORE_DEPTH];
    logic [7:0]    pal_mem    [PALETTE_DEPTH];

    logic [7:0]    spr_q_reg;
    logic [7:0]    nam_q_reg;
    logic [7:0]    pal_q_reg;

    logic          busy_reg;
    logic [NW-1:0] clr_cnt_reg;

    logic [12:0]   nam_diff;
    logic          nam_wrap;
    logic [NW-1:0] nam_idx;

    // Fold the 12-bit nametable offset into the store depth
    assign nam_diff = {1'b0, req.nam_addr} - 13'(NAME_STORE_DEPTH);
    assign nam_wrap = {1'b0, req.nam_addr} >= 13'(NAME_STORE_DEPTH);
    assign nam_idx  = nam_wrap ? nam_diff[NW-1:0] : req.nam_addr[NW-1:0];

    // Sweep every entry to zero once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + NW'(1);
            if (clr_cnt_reg == NW'(NAME_STORE_DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Nametable memory
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            name_mem[clr_cnt_reg] <= 8'h00;
        end
        else if (req.nam_we)
        begin
            name_mem[nam_idx] <= req.wdata;
        end
        if (req.nam_re)
        begin
            nam_q_reg <= name_mem[nam_idx];
        end
    end

    // Sprite memory
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (clr_cnt_reg < NW'(SPRITE_DEPTH))
            begin
                sprite_mem[clr_cnt_reg[7:0]] <= 8'h00;
            end
        end
        else if (req.spr_we)
        begin
            sprite_mem[req.spr_addr] <= req.wdata;
        end
        if (req.spr_re)
        begin
            spr_q_reg <= sprite_mem[req.spr_addr];
        end
    end

    // Palette memory
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (clr_cnt_reg < NW'(PALETTE_DEPTH))
            begin
                pal_mem[clr_cnt_reg[4:0]] <= 8'h00;
            end
        end
        else if (req.pal_we)
        begin
            pal_mem[req.pal_addr] <= req.wdata;
        end
        if (req.pal_re)
        begin
            pal_q_reg <= pal_mem[req.pal_addr];
        end
    end

    assign rsp.busy  = busy_reg;
    assign rsp.spr_q = spr_q_reg;
    assign rsp.nam_q = nam_q_reg;
    assign rsp.pal_q = pal_q_reg;

endmodule

// ===== rtl/video_unit_register_interface.sv =====
// Top level: register decode, raster timing and the two-stage result pipeline.
//
// Input channel: one word per item (cmd, reg_addr, write_data) under in_valid and
// in_stall. cmd selects a dot tick, a register read or a register write.
// Output channel: one word per item (read_data, nmi_request, frame_end, vblank)
// under out_valid and out_stall, in input order.
// Path: an accepted word enters the memory read stage and then the output register.
// Throughput: one item per cycle while in_stall is low; each item makes at most one
// access, to one of the stores, in the cycle it is accepted.
// Reset: all control state clears at once, then a clearing sweep walks
// NAME_STORE_DEPTH entries, writing zero to the stores one entry a cycle; in_stall
// stays high until it ends.
// Receiver stall: the output register holds its word; one more item still enters
// the read stage, after which in_stall rises until the output word is taken.
`include "video_unit_register_interface_macros.svh"

module video_unit_register_interface #(
    parameter int NAME_STORE_DEPTH = vuri_pkg::NAME_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [2:0] reg_addr,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       nmi_request,
    output logic       frame_end,
    output logic       vblank
);
    import vuri_pkg::*;

    // Architectural state
    logic [7:0]  control_reg,     control_next;
    logic        vblank_reg,      vblank_next;
    logic [7:0]  sprite_addr_reg, sprite_addr_next;
    logic [7:0]  read_buffer_reg;
    logic [13:0] vram_addr_reg,   vram_addr_next;
    logic        toggle_reg,      toggle_next;
    logic [8:0]  dot_count_reg,   dot_count_next;
    logic [8:0]  line_count_reg,  line_count_next;

    // Read stage
    logic        s1_valid_reg;
    logic [7:0]  s1_rd_reg;
    logic        s1_rd_spr_reg;
    logic        s1_nmi_reg;
    logic        s1_fend_reg;
    logic        s1_vbl_reg;
    logic        s1_fill_reg;
    fill_src_t   s1_fill_src_reg;

    // Output register
    logic        s2_valid_reg;
    logic [7:0]  read_data_reg;
    logic        nmi_reg;
    logic        fend_reg;
    logic        vbl_out_reg;

    mem_req_t    mem_req;
    mem_rsp_t    mem_rsp;

    logic        in_acc;
    logic        out_acc;
    logic        s2_free;
    logic        s1_adv;

    logic [7:0]  fill_val;
    logic [7:0]  buf_cur;
    logic [8:0]  dot_inc;
    logic [8:0]  line_inc;
    logic [13:0] vram_adv;
    logic        in_pattern;
    logic        in_name;

    logic [7:0]  rd;
    logic        rd_spr;
    logic        nmi;
    logic        fend;
    logic        fill;
    fill_src_t   fill_src;

    vuri_store #(
        .NAME_STORE_DEPTH(NAME_STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mem_req),
        .rsp  (mem_rsp)
    );

    // Handshake and pipeline advance
    assign out_acc  = s2_valid_reg && !out_stall;
    assign s2_free  = !s2_valid_reg || out_acc;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_stall = mem_rsp.busy || (s1_valid_reg && !s2_free);
    assign in_acc   = in_valid && !in_stall;

    // Refill value of a data read in the read stage; forward it over the buffer
    always_comb
    begin
        case (s1_fill_src_reg)
            FILL_NAME: fill_val = mem_rsp.nam_q;
            FILL_PAL:  fill_val = mem_rsp.pal_q;
            default:   fill_val = 8'h00;
        endcase
    end

    assign buf_cur = (s1_valid_reg && s1_fill_reg) ? fill_val : read_buffer_reg;

    assign dot_inc    = dot_count_reg + 9'd1;
    assign line_inc   = line_count_reg + 9'd1;
    assign vram_adv   = vram_addr_reg + (control_reg[CTRL_INC32_BIT] ? INC_ROW : INC_ONE);
    assign in_pattern = vram_addr_reg < NAME_BASE;
    assign in_name    = vram_addr_reg < PALETTE_BASE;

    // Decode one word: update state, issue store access, form the result
    always_comb
    begin
        control_next     = control_reg;
        vblank_next      = vblank_reg;
        sprite_addr_next = sprite_addr_reg;
        vram_addr_next   = vram_addr_reg;
        toggle_next      = toggle_reg;
        dot_count_next   = dot_count_reg;
        line_count_next  = line_count_reg;
        mem_req          = '0;
        mem_req.wdata    = write_data;
        rd               = 8'h00;
        rd_spr           = 1'b0;
        nmi              = 1'b0;
        fend             = 1'b0;
        fill             = 1'b0;
        fill_src         = FILL_ZERO;
        if (in_acc)
        begin
            case (cmd)
                CMD_TICK:
                begin
                    if (dot_inc >= DOTS_PER_LINE)
                    begin
                        dot_count_next  = 9'd0;
                        line_count_next = line_inc;
                        if (line_inc == VBLANK_LINE)
                        begin
                            vblank_next = 1'b1;
                            nmi         = control_reg[CTRL_NMI_BIT];
                        end
                        else if (line_inc >= LINES_PER_FRAME)
                        begin
                            line_count_next = 9'd0;
                            fend            = 1'b1;
                            vblank_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        dot_count_next = dot_inc;
                    end
                end
                CMD_READ:
                begin
                    case (reg_addr)
                        REG_STATUS:
                        begin
                            rd          = {vblank_reg, 2'b00, buf_cur[4:0]};
                            vblank_next = 1'b0;
                            toggle_next = 1'b0;
                        end
                        REG_SPR_DATA:
                        begin
                            mem_req.spr_re   = 1'b1;
                            mem_req.spr_addr = sprite_addr_reg;
                            rd_spr           = 1'b1;
                        end
                        REG_DATA:
                        begin
                            rd   = buf_cur;
                            fill = 1'b1;
                            if (in_pattern)
                            begin
                                fill_src = FILL_ZERO;
                            end
                            else if (in_name)
                            begin
                                mem_req.nam_re   = 1'b1;
                                mem_req.nam_addr = vram_addr_reg[11:0];
                                fill_src         = FILL_NAME;
                            end
                            else
                            begin
                                mem_req.pal_re   = 1'b1;
                                mem_req.pal_addr = pal_index(vram_addr_reg[4:0]);
                                fill_src         = FILL_PAL;
                            end
                            vram_addr_next = vram_adv;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_WRITE:
                begin
                    case (reg_addr)
                        REG_CTRL:
                        begin
                            control_next = write_data;
                        end
                        REG_SPR_ADDR:
                        begin
                            sprite_addr_next = write_data;
                        end
                        REG_SPR_DATA:
                        begin
                            mem_req.spr_we   = 1'b1;
                            mem_req.spr_addr = sprite_addr_reg;
                            sprite_addr_next = sprite_addr_reg + 8'd1;
                        end
                        REG_SCROLL:
                        begin
                            toggle_next = !toggle_reg;
                        end
                        REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                vram_addr_next = {write_data[5:0], vram_addr_reg[7:0]};
                            end
                            else
                            begin
                                vram_addr_next = {vram_addr_reg[13:8], write_data};
                            end
                            toggle_next = !toggle_reg;
                        end
                        REG_DATA:
                        begin
                            if (!in_pattern)
                            begin
                                if (in_name)
                                begin
                                    mem_req.nam_we   = 1'b1;
                                    mem_req.nam_addr = vram_addr_reg[11:0];
                                end
                                else
                                begin
                                    mem_req.pal_we   = 1'b1;
                                    mem_req.pal_addr = pal_index(vram_addr_reg[4:0]);
                                end
                            end
                            vram_addr_next = vram_adv;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // Commit architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg     <= 8'h00;
            vblank_reg      <= 1'b0;
            sprite_addr_reg <= 8'h00;
            read_buffer_reg <= 8'h00;
            vram_addr_reg   <= 14'h0000;
            toggle_reg      <= 1'b0;
            dot_count_reg   <= 9'd0;
            line_count_reg  <= 9'd0;
        end
        else
        begin
            control_reg     <= control_next;
            vblank_reg      <= vblank_next;
            sprite_addr_reg <= sprite_addr_next;
            vram_addr_reg   <= vram_addr_next;
            toggle_reg      <= toggle_next;
            dot_count_reg   <= dot_count_next;
            line_count_reg  <= line_count_next;
            if (s1_adv && s1_fill_reg)
            begin
                read_buffer_reg <= fill_val;
            end
        end
    end

    // Read stage: hold the word while the store data comes back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_rd_reg       <= rd;
            s1_rd_spr_reg   <= rd_spr;
            s1_nmi_reg      <= nmi;
            s1_fend_reg     <= fend;
            s1_vbl_reg      <= vblank_next;
            s1_fill_reg     <= fill;
            s1_fill_src_reg <= fill_src;
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            read_data_reg <= s1_rd_spr_reg ? mem_rsp.spr_q : s1_rd_reg;
            nmi_reg       <= s1_nmi_reg;
            fend_reg      <= s1_fend_reg;
            vbl_out_reg   <= s1_vbl_reg;
        end
    end

    assign out_valid   = s2_valid_reg;
    assign read_data   = read_data_reg;
    assign nmi_request = nmi_reg;
    assign frame_end   = fend_reg;
    assign vblank      = vbl_out_reg;

    // Checks
    `VURI_ASSERT_NOW(a_count_range, 1'b1, (dot_count_reg < DOTS_PER_LINE) && (line_count_reg < LINES_PER_FRAME), "raster counter out of range")
    `VURI_ASSERT_NOW(a_nmi_in_vblank, out_valid && nmi_request, vblank && !frame_end, "nmi word without vblank")
    `VURI_ASSERT_NOW(a_frame_end_clears, out_valid && frame_end, !vblank, "frame end word with vblank set")
    `VURI_ASSERT_NEXT(a_clear_once, !mem_rsp.busy, !mem_rsp.busy, "store clearing restarted")

endmodule

// ===== bench/video_unit_register_interface_test.sv =====
// Self-checking bench for the video unit register interface against a shadow of its state.
module video_unit_register_interface_test;
    import vuri_pkg::*;

    localparam int NAME_DEPTH    = NAME_DEPTH_DEF;
    localparam int ITEM_TARGET   = 950;
    localparam int TICK_TARGET   = 300;
    localparam int ACCESS_TARGET = ITEM_TARGET - TICK_TARGET;
    localparam int TAIL_WORDS    = 150;
    localparam int REPORT_LIMIT  = 10;
    localparam int DRAIN_CYCLES  = 8;

    // The one command code the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] sel;
        logic [7:0] wbyte;
    } bus_word_t;

    typedef struct packed {
        logic [7:0] data;
        logic       nmi;
        logic       fend;
        logic       vbl;
    } unit_reply_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] cmd = CMD_TICK;
    logic [2:0] reg_addr = REG_CTRL;
    logic [7:0] write_data = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] read_data;
    logic       nmi_request;
    logic       frame_end;
    logic       vblank;

    bus_word_t   access_queue[$];
    unit_reply_t response_queue[$];

    int fault_count = 0;
    int accepted_words = 0;
    int total_words = 0;
    int responses_seen = 0;
    int ticks_queued = 0;
    int accesses_queued = 0;
    int send_gap = 0;
    int recv_hold = 0;

    // Shadow copy of the unit state
    logic [7:0]  ctrl_shadow;
    logic        vbl_shadow;
    logic [7:0]  spr_ptr;
    logic [7:0]  spr_shadow [SPRITE_DEPTH];
    logic [7:0]  nam_shadow [NAME_DEPTH];
    logic [7:0]  pal_shadow [PALETTE_DEPTH];
    logic [7:0]  rbuf_shadow;
    logic [13:0] vaddr_shadow;
    logic        toggle_shadow;
    logic [8:0]  dot_shadow;
    logic [8:0]  line_shadow;

    video_unit_register_interface #(.NAME_STORE_DEPTH(NAME_DEPTH)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .reg_addr(reg_addr),
        .write_data(write_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .nmi_request(nmi_request),
        .frame_end(frame_end),
        .vblank(vblank)
    );

    always #4 clk = ~clk;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Fold the upper backdrop entries onto the lower half
    function automatic logic [4:0] fold_palette(logic [13:0] a);
        logic [4:0] idx;
        idx = a[4:0];
        if (idx[4] && idx[1:0] == 2'b00)
            idx[4] = 1'b0;
        return idx;
    endfunction

    function automatic int name_slot(logic [13:0] a);
        return int'(a[11:0]) % NAME_DEPTH;
    endfunction

    function automatic logic [7:0] vram_fetch(logic [13:0] a);
        if (a < NAME_BASE)
            return 8'h00;
        if (a < PALETTE_BASE)
            return nam_shadow[name_slot(a)];
        return pal_shadow[fold_palette(a)];
    endfunction

    function automatic void vram_store(logic [13:0] a, logic [7:0] v);
        if (a >= PALETTE_BASE)
            pal_shadow[fold_palette(a)] = v;
        else if (a >= NAME_BASE)
            nam_shadow[name_slot(a)] = v;
    endfunction

    function automatic void bump_vram_addr();
        vaddr_shadow = vaddr_shadow + (ctrl_shadow[CTRL_INC32_BIT] ? INC_ROW : INC_ONE);
    endfunction

    // Apply one bus word to the shadow state and return the reply it causes
    function automatic unit_reply_t step_video_unit(bus_word_t w);
        unit_reply_t r;
        r = '0;
        case (w.op)
            CMD_TICK:
            begin
                dot_shadow = dot_shadow + 9'd1;
                if (dot_shadow >= DOTS_PER_LINE)
                begin
                    dot_shadow = '0;
                    line_shadow = line_shadow + 9'd1;
                    if (line_shadow == VBLANK_LINE)
                    begin
                        vbl_shadow = 1'b1;
                        r.nmi = ctrl_shadow[CTRL_NMI_BIT];
                    end
                    else if (line_shadow >= LINES_PER_FRAME)
                    begin
                        line_shadow = '0;
                        r.fend = 1'b1;
                        vbl_shadow = 1'b0;
                    end
                end
            end
            CMD_READ:
            begin
                case (w.sel)
                    REG_STATUS:
                    begin
                        r.data = {vbl_shadow, 2'b00, rbuf_shadow[4:0]};
                        vbl_shadow = 1'b0;
                        toggle_shadow = 1'b0;
                    end
                    REG_SPR_DATA:
                        r.data = spr_shadow[spr_ptr];
                    REG_DATA:
                    begin
                        r.data = rbuf_shadow;
                        rbuf_shadow = vram_fetch(vaddr_shadow);
                        bump_vram_addr();
                    end
                    default: ;
                endcase
            end
            CMD_WRITE:
            begin
                case (w.sel)
                    REG_CTRL:
                        ctrl_shadow = w.wbyte;
                    REG_SPR_ADDR:
                        spr_ptr = w.wbyte;
                    REG_SPR_DATA:
                    begin
                        spr_shadow[spr_ptr] = w.wbyte;
                        spr_ptr = spr_ptr + 8'd1;
                    end
                    REG_SCROLL:
                        toggle_shadow = ~toggle_shadow;
                    REG_ADDR:
                    begin
                        if (!toggle_shadow)
                            vaddr_shadow = {w.wbyte[5:0], vaddr_shadow[7:0]};
                        else
                            vaddr_shadow = {vaddr_shadow[13:8], w.wbyte};
                        toggle_shadow = ~toggle_shadow;
                    end
                    REG_DATA:
                    begin
                        vram_store(vaddr_shadow, w.wbyte);
                        bump_vram_addr();
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.vbl = vbl_shadow;
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void log_fault(string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    function automatic void push_word(logic [1:0] op, logic [2:0] sel, logic [7:0] wbyte);
        bus_word_t w;
        w.op = op;
        w.sel = sel;
        w.wbyte = wbyte;
        access_queue.push_back(w);
        if (op == CMD_TICK)
            ticks_queued++;
        else if (op != CMD_UNUSED)
            accesses_queued++;
    endfunction

    function automatic void push_ticks(int n);
        for (int i = 0; i < n; i++)
            push_word(CMD_TICK, 3'($urandom_range(0, 7)), rand_byte());
    endfunction

    // Driver: feed words from the queue, with random idle bursts
    always @(posedge clk)
    begin : driver
        bus_word_t sent;
        bus_word_t next_word;
        if (rst_n)
        begin
            // Retire the word taken at this edge and predict its reply
            if (in_valid && !in_stall)
            begin
                sent.op = cmd;
                sent.sel = reg_addr;
                sent.wbyte = write_data;
                response_queue.push_back(step_video_unit(sent));
                accepted_words++;
            end
            // Load the next word unless a stalled one must hold
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (access_queue.size() == 0)
                    in_valid <= 1'b0;
                else if (access_queue.size() > TAIL_WORDS && $urandom_range(0, 15) == 0)
                begin
                    send_gap = $urandom_range(0, 13);
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_word = access_queue.pop_front();
                    cmd <= next_word.op;
                    reg_addr <= next_word.sel;
                    write_data <= next_word.wbyte;
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each reply word, and stall the output in random bursts
    always @(posedge clk)
    begin : monitor
        unit_reply_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (response_queue.size() == 0)
                    log_fault($sformatf("reply %0d with none pending: data %02h nmi %b fend %b vbl %b",
                        responses_seen, read_data, nmi_request, frame_end, vblank));
                else
                begin
                    want = response_queue.pop_front();
                    if (read_data !== want.data || nmi_request !== want.nmi
                        || frame_end !== want.fend || vblank !== want.vbl)
                        log_fault($sformatf({"reply %0d (expected/actual): data %02h/%02h ",
                            "nmi %b/%b frame_end %b/%b vblank %b/%b"}, responses_seen,
                            want.data, read_data, want.nmi, nmi_request,
                            want.fend, frame_end, want.vbl, vblank));
                end
                responses_seen++;
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_stall <= 1'b1;
            end
            else if (access_queue.size() > TAIL_WORDS && $urandom_range(0, 15) == 0)
            begin
                recv_hold = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int span;
        int pick;
        int burst;
        logic [7:0] hi_byte;
        logic [7:0] lo_byte;
        logic [7:0] spr_base;
        logic [7:0] ctrl_byte;

        // Start the shadow from the reset state
        ctrl_shadow = '0;
        vbl_shadow = 1'b0;
        spr_ptr = '0;
        rbuf_shadow = '0;
        vaddr_shadow = '0;
        toggle_shadow = 1'b0;
        dot_shadow = '0;
        line_shadow = '0;
        for (int i = 0; i < SPRITE_DEPTH; i++)
            spr_shadow[i] = '0;
        for (int i = 0; i < NAME_DEPTH; i++)
            nam_shadow[i] = '0;
        for (int i = 0; i < PALETTE_DEPTH; i++)
            pal_shadow[i] = '0;

        // Directed words: reset values, write-only and read-only registers,
        // address wrap, pattern area, palette mirror, sprite pointer wrap
        push_word(CMD_TICK, REG_DATA, 8'hFF);
        push_word(CMD_READ, REG_CTRL, 8'h00);
        push_word(CMD_WRITE, REG_STATUS, 8'hFF);
        push_word(CMD_READ, REG_STATUS, 8'h00);
        push_word(CMD_WRITE, REG_CTRL, 8'h84);
        push_word(CMD_WRITE, REG_ADDR, 8'hFF);
        push_word(CMD_WRITE, REG_ADDR, 8'hFF);
        push_word(CMD_WRITE, REG_DATA, 8'hA5);
        push_word(CMD_WRITE, REG_DATA, 8'h5A);
        push_word(CMD_WRITE, REG_CTRL, 8'h00);
        push_word(CMD_WRITE, REG_ADDR, 8'h3F);
        push_word(CMD_WRITE, REG_ADDR, 8'h10);
        push_word(CMD_WRITE, REG_DATA, 8'h77);
        push_word(CMD_WRITE, REG_ADDR, 8'h3F);
        push_word(CMD_WRITE, REG_ADDR, 8'h00);
        push_word(CMD_READ, REG_DATA, 8'h00);
        push_word(CMD_READ, REG_DATA, 8'h00);
        push_word(CMD_WRITE, REG_SCROLL, 8'h12);
        push_word(CMD_READ, REG_STATUS, 8'h00);
        push_word(CMD_WRITE, REG_MASK, 8'hFF);
        push_word(CMD_READ, REG_MASK, 8'h00);
        push_word(CMD_WRITE, REG_SPR_ADDR, 8'hFF);
        push_word(CMD_WRITE, REG_SPR_DATA, 8'h3C);
        push_word(CMD_WRITE, REG_SPR_ADDR, 8'hFF);
        push_word(CMD_READ, REG_SPR_DATA, 8'h00);
        push_word(CMD_UNUSED, REG_DATA, 8'hFF);

        // Random part: short tick runs spread through the run, each followed by accesses
        while (accesses_queued < ACCESS_TARGET)
        begin
            span = 0;
            if (ticks_queued < TICK_TARGET)
                span = (TICK_TARGET - ticks_queued) * 5 / (ACCESS_TARGET - accesses_queued + 5);
            push_ticks($urandom_range(0, 2 * span));
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                // Set the video address, then stream data reads and writes
                if ($urandom_range(0, 1) == 0)
                    push_word(CMD_READ, REG_STATUS, rand_byte());
                case ($urandom_range(0, 5))
                    0: hi_byte = 8'h20;
                    1: hi_byte = 8'h2C;
                    2: hi_byte = 8'h30;
                    3, 4: hi_byte = 8'h3F;
                    default: hi_byte = rand_byte();
                endcase
                lo_byte = rand_byte();
                if ($urandom_range(0, 1) == 0)
                    lo_byte[7:3] = '0;
                push_word(CMD_WRITE, REG_ADDR, hi_byte);
                push_word(CMD_WRITE, REG_ADDR, lo_byte);
                burst = $urandom_range(1, 8);
                repeat (burst)
                    push_word($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, REG_DATA, rand_byte());
            end
            else if (pick < 6)
            begin
                // Fill sprite entries, then read them back
                spr_base = rand_byte();
                if ($urandom_range(0, 1) == 0)
                    spr_base[7:3] = 5'b11111;
                burst = $urandom_range(1, 4);
                push_word(CMD_WRITE, REG_SPR_ADDR, spr_base);
                repeat (burst)
                    push_word(CMD_WRITE, REG_SPR_DATA, rand_byte());
                repeat (burst)
                begin
                    push_word(CMD_WRITE, REG_SPR_ADDR, spr_base);
                    push_word(CMD_READ, REG_SPR_DATA, rand_byte());
                    spr_base = spr_base + 8'd1;
                end
            end
            else if (pick == 6)
            begin
                // Rewrite control with NMI enabled about half the time
                ctrl_byte = rand_byte();
                ctrl_byte[CTRL_NMI_BIT] = ($urandom_range(0, 1) == 0);
                push_word(CMD_WRITE, REG_CTRL, ctrl_byte);
            end
            else if (pick == 7)
            begin
                if ($urandom_range(0, 1) == 0)
                    push_word(CMD_WRITE, REG_SCROLL, rand_byte());
                push_word(CMD_READ, REG_STATUS, rand_byte());
            end
            else
                repeat ($urandom_range(1, 4))
                    push_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rand_byte());
        end
        push_ticks(TICK_TARGET - ticks_queued);
        total_words = access_queue.size();

        // Drain: wait for every word to be taken and answered
        while (accepted_words < total_words || response_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fault_count == 0 && response_queue.size() == 0)
            $display("video_unit_register_interface test passed");
        else
            $display("video_unit_register_interface test failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("video_unit_register_interface test failed");
        $finish;
    end

endmodule

// ===== video_unit_register_interface.f =====
+incdir+rtl
rtl/vuri_pkg.sv
rtl/vuri_store.sv
rtl/video_unit_register_interface.sv
bench/video_unit_register_interface_test.sv
